### rtl/lls_pkg.sv
package lls_pkg;

    // Field widths
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned COUNT_W  = 18;
    localparam int unsigned WORDS_W  = 16;
    localparam int unsigned OFFS_W   = 19;

    // Block layout
    localparam logic [COUNT_W-1:0] HDR_BYTES  = 18'd4;
    localparam logic [COUNT_W-1:0] LEN_LO_IDX = 18'd3;
    localparam logic [COUNT_W-1:0] COUNT_MAX  = 18'h3FFFF;
    localparam logic [OFFS_W-1:0]  TLV_START  = 19'd4;
    localparam logic [OFFS_W-1:0]  TLV_HDR_SZ = 19'd4;
    localparam logic [15:0]        SUM_ONES   = 16'hFFFF;

    // Verdict codes
    localparam logic [STATUS_W-1:0] ST_VALID     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_SHORT_HDR = 3'd1;
    localparam logic [STATUS_W-1:0] ST_SHORT_DAT = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_CSUM  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_TLV_LEN   = 3'd4;

    // Result queue depth
    localparam int unsigned RQ_DEPTH = 2;
    localparam int unsigned RQ_PTR_W = 1;
    localparam int unsigned RQ_CNT_W = 2;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              last_byte;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                trailing_ignored;
    } t_result;

endpackage

### rtl/lls_block_validator.sv
// Channel  | Handshake          | Payload              | Transfer when
// ---------+--------------------+----------------------+---------------------
// input    | push / full        | i_item (byte, last)  | push && !full
// result   | empty / pop        | o_result (verdict)   | pop && !empty
//
// One byte per cycle while full is low; the front updates count, checksum
// and TLV walk per byte and writes the last byte's verdict to a 2-entry queue.
// A verdict is visible on o_result the cycle after its last byte is taken if no older verdict waits.
// full rises only while two verdicts wait unread; bytes stall just then.
// Reset (i_rst_n low, synchronous) empties the queue and clears the front.
module lls_block_validator (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  lls_pkg::t_in_item i_item,
    output logic              empty,
    input  logic              pop,
    output lls_pkg::t_result  o_result
);

    logic             w_accept;
    logic             w_res_push;
    lls_pkg::t_result w_res;

    assign w_accept = push & ~full;

    lls_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_item     (i_item),
        .o_res_push (w_res_push),
        .o_res      (w_res)
    );

    lls_rq u_rq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_res   (w_res),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_res   (o_result)
    );

endmodule

### rtl/lls_front.sv
module lls_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  lls_pkg::t_in_item i_item,
    output logic              o_res_push,
    output lls_pkg::t_result  o_res
);

    logic [lls_pkg::COUNT_W-1:0] r_byte_count, n_byte_count;
    logic [15:0]                 r_sum, n_sum;
    logic [7:0]                  r_pending, n_pending;
    logic [lls_pkg::WORDS_W-1:0] r_decl, n_decl;
    logic [lls_pkg::OFFS_W-1:0]  r_tlv, n_tlv;
    logic [7:0]                  r_vhigh, n_vhigh;

    logic [15:0]                 w_word;
    logic [16:0]                 w_sum17;
    logic [lls_pkg::COUNT_W-1:0] w_decl_cur;
    logic [lls_pkg::COUNT_W-1:0] w_decl_bytes;
    logic [19:0]                 w_tlv_p2;
    logic [19:0]                 w_tlv_p3;
    logic [15:0]                 w_vlen;
    logic [16:0]                 w_padded;
    logic [lls_pkg::COUNT_W-1:0] w_len;

    assign w_word     = {r_pending, i_item.data_byte};
    assign w_sum17    = {1'b0, r_sum} + {1'b0, w_word};
    assign w_decl_cur = {r_decl, 2'b00};
    assign w_tlv_p2   = {1'b0, r_tlv} + 20'd2;
    assign w_tlv_p3   = {1'b0, r_tlv} + 20'd3;
    assign w_vlen     = {r_vhigh, i_item.data_byte};
    assign w_padded   = ({1'b0, w_vlen} + 17'd3) & ~17'd3;

    // Per-byte state update: word sum, header length, TLV walk, count
    always_comb begin
        n_pending    = r_pending;
        n_decl       = r_decl;
        n_sum        = r_sum;
        n_tlv        = r_tlv;
        n_vhigh      = r_vhigh;
        if (!r_byte_count[0]) begin
            n_pending = i_item.data_byte;
        end else begin
            if (r_byte_count == lls_pkg::LEN_LO_IDX) begin
                n_decl = w_word;
            end
            if (r_byte_count < lls_pkg::HDR_BYTES || r_byte_count < w_decl_cur) begin
                n_sum = w_sum17[15:0] + {15'd0, w_sum17[16]};
            end
        end
        if (r_byte_count >= lls_pkg::HDR_BYTES && r_tlv < {1'b0, w_decl_cur}) begin
            if ({2'b00, r_byte_count} == w_tlv_p2) begin
                n_vhigh = i_item.data_byte;
            end else if ({2'b00, r_byte_count} == w_tlv_p3) begin
                n_tlv = r_tlv + lls_pkg::TLV_HDR_SZ + {2'b00, w_padded};
            end
        end
        if (r_byte_count != lls_pkg::COUNT_MAX) begin
            n_byte_count = r_byte_count + 18'd1;
        end else begin
            n_byte_count = r_byte_count;
        end
    end

    assign w_decl_bytes = {n_decl, 2'b00};
    assign w_len        = n_byte_count;

    // Verdict on the last byte, first failing check wins
    always_comb begin
        o_res.trailing_ignored = 1'b0;
        priority if (w_len < lls_pkg::HDR_BYTES) begin
            o_res.status = lls_pkg::ST_SHORT_HDR;
        end else if (w_len < w_decl_bytes) begin
            o_res.status = lls_pkg::ST_SHORT_DAT;
        end else begin
            o_res.trailing_ignored = (w_len > w_decl_bytes);
            priority if (n_decl == '0 || n_sum != lls_pkg::SUM_ONES) begin
                o_res.status = lls_pkg::ST_BAD_CSUM;
            end else if (n_tlv != {1'b0, w_decl_bytes}) begin
                o_res.status = lls_pkg::ST_TLV_LEN;
            end else begin
                o_res.status = lls_pkg::ST_VALID;
            end
        end
    end

    assign o_res_push = i_accept & i_item.last_byte;

    // State registers; cleared by reset and after each block's last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_res_push) begin
            r_byte_count <= '0;
            r_sum        <= '0;
            r_pending    <= '0;
            r_decl       <= '0;
            r_tlv        <= lls_pkg::TLV_START;
            r_vhigh      <= '0;
        end else if (i_accept) begin
            r_byte_count <= n_byte_count;
            r_sum        <= n_sum;
            r_pending    <= n_pending;
            r_decl       <= n_decl;
            r_tlv        <= n_tlv;
            r_vhigh      <= n_vhigh;
        end
    end

    // A block's last byte leaves the walker at its starting point
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push |=> (r_byte_count == '0 && r_tlv == lls_pkg::TLV_START))
        else $error("front state not cleared after last byte");

    // Byte count moves only on a transfer
    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_accept |=> $stable(r_byte_count))
        else $error("byte count changed without a transfer");

endmodule

### rtl/lls_rq.sv
module lls_rq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  lls_pkg::t_result i_res,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_empty,
    output lls_pkg::t_result o_res
);

    lls_pkg::t_result              r_mem [lls_pkg::RQ_DEPTH];
    logic [lls_pkg::RQ_PTR_W-1:0]  r_wr_ptr;
    logic [lls_pkg::RQ_PTR_W-1:0]  r_rd_ptr;
    logic [lls_pkg::RQ_CNT_W-1:0]  r_count;
    logic                          w_wr;
    logic                          w_rd;

    assign o_full  = (r_count == lls_pkg::RQ_CNT_W'(lls_pkg::RQ_DEPTH));
    assign o_empty = (r_count == '0);
    assign w_wr    = i_push & ~o_full;
    assign w_rd    = i_pop & ~o_empty;
    assign o_res   = r_mem[r_rd_ptr];

    // Storage
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_res;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= lls_pkg::RQ_CNT_W'(lls_pkg::RQ_DEPTH))
        else $error("result queue over depth");

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("verdict pushed into a full queue");

endmodule

### tb/lls_verdict_checker.sv
`timescale 1ns / 1ps

// Watches both queue ports of the validator, keeps a shadow of its byte
// walk, and checks every popped verdict against the oldest predicted one.
module lls_verdict_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic              i_full,
    input  lls_pkg::t_in_item i_item,
    input  logic              i_empty,
    input  logic              i_pop,
    input  lls_pkg::t_result  i_result,
    output int                o_fail_count,
    output int                o_pending
);

    localparam int          MAX_REPORTS = 10;
    localparam int unsigned PAD_MASK    = 32'h3;

    // Shadow of the validator front end
    logic [lls_pkg::COUNT_W-1:0] rx_count;
    logic [15:0]                 csum_acc;
    logic [lls_pkg::BYTE_W-1:0]  word_hi;
    logic [lls_pkg::WORDS_W-1:0] len_words;
    logic [lls_pkg::OFFS_W-1:0]  tlv_next;
    logic [lls_pkg::BYTE_W-1:0]  vlen_hi;

    // Verdicts predicted but not yet popped
    lls_pkg::t_result verdict_q[$];
    int               mismatches = 0;

    task automatic clear_shadow();
        rx_count  = '0;
        csum_acc  = '0;
        word_hi   = '0;
        len_words = '0;
        tlv_next  = lls_pkg::TLV_START;
        vlen_hi   = '0;
    endtask

    // Fold one accepted byte into the shadow; on the last byte, form the verdict
    task automatic absorb_byte(input lls_pkg::t_in_item it, output logic done,
                               output lls_pkg::t_result verdict);
        int unsigned idx;
        int unsigned word;
        int unsigned sum;
        int unsigned decl;
        int unsigned vlen;
        int unsigned padded;
        int unsigned len;

        idx = 32'(rx_count);
        if (!idx[0]) begin
            word_hi = it.data_byte;
        end else begin
            word = 32'({word_hi, it.data_byte});
            if (idx == lls_pkg::LEN_LO_IDX) begin
                len_words = word[15:0];
            end
            // header words always; the rest only inside the declared length
            if (idx < lls_pkg::HDR_BYTES || idx < (32'(len_words) << 2)) begin
                sum = csum_acc + word;
                csum_acc = 16'(sum[15:0] + sum[16]);
            end
        end

        // TLV walk: pick up the value length, hop to the next header
        decl = 32'(len_words) << 2;
        if (idx >= lls_pkg::HDR_BYTES && tlv_next < decl) begin
            if (idx == tlv_next + 2) begin
                vlen_hi = it.data_byte;
            end else if (idx == tlv_next + 3) begin
                vlen = 32'({vlen_hi, it.data_byte});
                padded = (vlen + PAD_MASK) & ~PAD_MASK;
                tlv_next = lls_pkg::OFFS_W'(tlv_next + lls_pkg::TLV_HDR_SZ + padded);
            end
        end

        if (rx_count < lls_pkg::COUNT_MAX) begin
            rx_count = rx_count + 1'b1;
        end

        done = it.last_byte;
        verdict = '0;
        if (done) begin
            len = 32'(rx_count);
            if (len < lls_pkg::HDR_BYTES) begin
                verdict.status = lls_pkg::ST_SHORT_HDR;
            end else if (len < decl) begin
                verdict.status = lls_pkg::ST_SHORT_DAT;
            end else begin
                verdict.trailing_ignored = (len > decl);
                if (len_words == 0 || csum_acc != lls_pkg::SUM_ONES) begin
                    verdict.status = lls_pkg::ST_BAD_CSUM;
                end else if (tlv_next != decl) begin
                    verdict.status = lls_pkg::ST_TLV_LEN;
                end else begin
                    verdict.status = lls_pkg::ST_VALID;
                end
            end
            clear_shadow();
        end
    endtask

    // Compare popped verdicts first (they are older), then absorb the new byte
    always @(posedge i_clk) begin
        lls_pkg::t_result want;
        lls_pkg::t_result verdict;
        logic             done;

        if (!i_rst_n) begin
            clear_shadow();
            verdict_q.delete();
        end else begin
            if (i_pop && !i_empty) begin
                if (verdict_q.size() == 0) begin
                    if (mismatches < MAX_REPORTS) begin
                        $display("%0t: unpredicted verdict: status %0d trailing %0b",
                                 $realtime, i_result.status, i_result.trailing_ignored);
                    end
                    mismatches++;
                end else begin
                    want = verdict_q.pop_front();
                    if (want.status !== i_result.status ||
                        want.trailing_ignored !== i_result.trailing_ignored) begin
                        if (mismatches < MAX_REPORTS) begin
                            $display("%0t: expected status %0d trailing %0b, got %0d %0b",
                                     $realtime, want.status, want.trailing_ignored,
                                     i_result.status, i_result.trailing_ignored);
                        end
                        mismatches++;
                    end
                end
            end
            if (i_push && !i_full) begin
                absorb_byte(i_item, done, verdict);
                if (done) begin
                    verdict_q.push_back(verdict);
                end
            end
        end
        o_pending    <= verdict_q.size();
        o_fail_count <= mismatches;
    end

endmodule

### tb/tb_lls_block_validator.sv
`timescale 1ns / 1ps

module tb_lls_block_validator;

    localparam int CYCLE_LIMIT  = 1_200_000;
    localparam int RESET_CYCLES = 9;
    localparam int DRAIN_CYCLES = 10;
    localparam int RANDOM_BYTES = 1750;
    localparam int HOLD_CYCLES  = 400;
    localparam int MAX_SPAN     = 65532;
    localparam int SEND_IDLE [4] = '{0, 60, 0, 35};
    localparam int RECV_STALL[4] = '{0, 0, 60, 35};

    // Ways a random block departs from a well-formed one
    typedef enum int {FL_NONE, FL_CSUM, FL_TLV, FL_SHORT, FL_TRAIL, FL_NOISE} t_flaw;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              push;
    logic              full;
    lls_pkg::t_in_item i_item;
    logic              empty;
    logic              pop;
    lls_pkg::t_result  o_result;

    int fail_count;
    int pending;
    int cycle_count    = 0;
    int bytes_sent     = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_req       = 0;

    // Block under construction
    logic [7:0]  blk[$];
    int unsigned tlv_at[$];

    lls_block_validator uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

    lls_verdict_checker u_verdict_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_full       (full),
        .i_item       (i_item),
        .i_empty      (empty),
        .i_pop        (pop),
        .i_result     (o_result),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #2 i_clk = ~i_clk;

    // Run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Result side: random stalls, plus one long hold-off when requested
    initial begin
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        pop <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req != hold_seen) begin
                hold_left = HOLD_CYCLES;
                hold_seen = hold_req;
            end
            if (!i_rst_n) begin
                pop <= 1'b0;
            end else if (hold_left > 0) begin
                pop <= 1'b0;
                hold_left--;
            end else begin
                pop <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // One byte transfer, with random idle cycles ahead of it
    task automatic send_byte(input logic [7:0] b, input logic last);
        lls_pkg::t_in_item it;
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        it.data_byte = b;
        it.last_byte = last;
        push   <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (full);
        bytes_sent++;
    endtask

    task automatic send_block();
        for (int i = 0; i < blk.size(); i++) begin
            send_byte(blk[i], i == blk.size() - 1);
        end
    endtask

    // Build a block with a TLV chain filling the declared length and a
    // checksum that makes it valid, then apply the requested flaw
    task automatic build_block(input int unsigned words, input t_flaw flaw);
        int unsigned decl;
        int unsigned left;
        int unsigned room;
        int unsigned span;
        int unsigned vlen;
        int unsigned pos;
        int unsigned total;
        int unsigned cut;
        logic [15:0] csum;

        blk.delete();
        tlv_at.delete();
        decl = words * 4;
        blk.push_back(8'h00);
        blk.push_back(8'h00);
        blk.push_back(words[15:8]);
        blk.push_back(words[7:0]);
        left = (decl > 4) ? decl - 4 : 0;
        while (left >= 4) begin
            room = left - 4;
            if (room > MAX_SPAN) begin
                room = MAX_SPAN;
            end
            span = 4 * $urandom_range(room / 4);
            vlen = (span == 0) ? 0 : span - $urandom_range(3);
            tlv_at.push_back(blk.size());
            blk.push_back(8'($urandom_range(255)));
            blk.push_back(8'($urandom_range(255)));
            blk.push_back(vlen[15:8]);
            blk.push_back(vlen[7:0]);
            repeat (span) blk.push_back(8'($urandom_range(255)));
            left -= 4 + span;
        end

        // change one value length by a multiple of 4 so the chain misses the end
        if (flaw == FL_TLV && tlv_at.size() > 0) begin
            pos = tlv_at[$urandom_range(tlv_at.size() - 1)];
            vlen = {blk[pos + 2], blk[pos + 3]} ^ (32'd4 << $urandom_range(13));
            blk[pos + 2] = vlen[15:8];
            blk[pos + 3] = vlen[7:0];
        end

        // checksum so that the whole declared range sums to all ones
        if (decl == 0) begin
            csum = 16'($urandom_range(16'hFFFF));
        end else begin
            total = 0;
            for (int k = 2; k < decl; k += 2) begin
                total += {blk[k], blk[k + 1]};
                total = total[15:0] + total[31:16];
            end
            csum = ~total[15:0];
        end
        blk[0] = csum[15:8];
        blk[1] = csum[7:0];

        case (flaw)
            FL_CSUM: begin
                if (decl > 0) begin
                    pos = $urandom_range(decl - 1);
                    blk[pos] = blk[pos] ^ (8'h01 << $urandom_range(7));
                end
            end
            FL_TRAIL: begin
                repeat ($urandom_range(1, 9)) blk.push_back(8'($urandom_range(255)));
            end
            FL_SHORT: begin
                cut = $urandom_range(1, blk.size() - 1);
                while (blk.size() > cut) void'(blk.pop_back());
            end
            FL_NOISE: begin
                blk.delete();
                repeat ($urandom_range(1, 24)) blk.push_back(8'($urandom_range(255)));
            end
            default: begin
            end
        endcase
    endtask

    initial begin
        int          phase_end;
        int unsigned r;
        int unsigned words;
        t_flaw       flaw;

        i_rst_n <= 1'b0;
        push    <= 1'b0;
        i_item  <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: lone last byte, short header, zero length with all-ones
        // checksum, header-only block, one empty TLV, data shorter than declared
        blk = {8'h00};
        send_block();
        blk = {8'hFF, 8'hFF, 8'hFF};
        send_block();
        blk = {8'hFF, 8'hFF, 8'h00, 8'h00};
        send_block();
        build_block(1, FL_NONE);
        send_block();
        build_block(2, FL_NONE);
        send_block();
        build_block(2, FL_NONE);
        repeat (3) void'(blk.pop_back());
        send_block();

        // Largest declared length, with only a few bytes behind the header
        blk = {8'h5A, 8'hA5, 8'hFF, 8'hFF, 8'h00, 8'h01, 8'h00, 8'h08};
        send_block();
        bytes_sent = 0;

        // Random blocks over the idle/stall phases
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = SEND_IDLE[ph];
            recv_stall_pct = RECV_STALL[ph];
            if (ph == 0) begin
                hold_req++;
            end
            phase_end = bytes_sent + RANDOM_BYTES / 4;
            while (bytes_sent < phase_end) begin
                r = $urandom_range(99);
                if (r < 45)      flaw = FL_NONE;
                else if (r < 57) flaw = FL_CSUM;
                else if (r < 69) flaw = FL_TLV;
                else if (r < 79) flaw = FL_SHORT;
                else if (r < 91) flaw = FL_TRAIL;
                else             flaw = FL_NOISE;
                words = ($urandom_range(99) < 5) ? 0 : $urandom_range(1, 8);
                build_block(words, flaw);
                send_block();
            end
        end
        push <= 1'b0;

        // Drain: let every predicted verdict come out
        recv_stall_pct = 0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
